@@ hw/rtl/grind_pkg.sv @@
// Package for the debounced grinder controller: register map, reset values
// of the configuration registers and the constants of the grind-time scaling.
// No dependencies.
package grind_pkg;

  // Default number of 10 ms ticks in one second of countdown.
  localparam int TICKS_PER_SECOND = 100;

  // Significant bits of the potentiometer reading; the port is 12 bits wide.
  localparam int ADC_BITS = 12;
  localparam int AdcW     = 12;
  localparam logic [AdcW-1:0] ADC_MASK =
      (ADC_BITS >= AdcW) ? {AdcW{1'b1}} : AdcW'((1 << ADC_BITS) - 1);

  // Division by 25 as a multiply by a rounded-up reciprocal. With a 12-bit
  // dividend the error term stays below one quotient step, so it is exact.
  localparam int           DIV25_SHIFT = 17;
  localparam logic [12:0]  DIV25_MUL   = 13'd5243;

  // APB register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_PAUSE_SECONDS  = 3'd0,
    REG_GRIND_OFFSET   = 3'd1,
    REG_PRESS_GAIN     = 3'd2,
    REG_RELEASE_GAIN   = 3'd3,
    REG_DEBOUNCE_LIMIT = 3'd4,
    REG_RAMP_STEP      = 3'd5,
    REG_RAMP_PEAK      = 3'd6
  } cfg_reg_e;

  // Register reset values.
  localparam logic [7:0]  PAUSE_SECONDS_RST  = 8'd20;
  localparam logic [5:0]  GRIND_OFFSET_RST   = 6'd5;
  localparam logic [5:0]  PRESS_GAIN_RST     = 6'd30;
  localparam logic [5:0]  RELEASE_GAIN_RST   = 6'd10;
  localparam logic [6:0]  DEBOUNCE_LIMIT_RST = 7'd100;
  localparam logic [7:0]  RAMP_STEP_RST      = 8'd8;
  localparam logic [11:0] RAMP_PEAK_RST      = 12'd2048;

  // Brightest level the blue lamp can be driven to.
  localparam logic [11:0] BLUE_MAX = 12'd4095;

endpackage

@@ hw/rtl/grinder_controller_debounced.sv @@
// Debounced grinder controller: one transaction per 10 ms tick, six-state
// controller with debouncer, countdowns and idle breathing ramp.
// Depends on grind_pkg.
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  ------------------------------------
//  tick in   input      in_valid_i/in_ready_o  button, joystick, trip, adc sample
//  result    output     out_valid_o/out_ready_i state, motor, green, red, blue level
//  config    input      APB psel/penable       seven registers at 4*index
//
// The block takes one tick transaction per clock cycle while results are taken
// without a stall. A tick is captured in an input register; once the result
// slot is free, a single pass of logic steps the controller and loads the
// state registers, which double as the result register, so the result is on
// the outputs from the clock edge that steps the controller.
// Reset clears the controller to Safe with all lamps and the motor off.
// While a result waits for out_ready_i, one more tick can sit in the input
// register; the controller does not step until the waiting result is taken.
module grinder_controller_debounced
  import grind_pkg::*;
#(
  parameter int TicksPerSecond = TICKS_PER_SECOND
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick transactions.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        button_level_i,
  input  logic        joystick_centre_i,
  input  logic        safety_trip_i,
  input  logic [11:0] adc_sample_i,
  input  logic        adc_valid_i,
  // Result transactions.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  ctrl_state_o,
  output logic        motor_on_o,
  output logic        green_led_o,
  output logic        red_led_o,
  output logic [11:0] blue_level_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PhaseW = (TicksPerSecond > 1) ? $clog2(TicksPerSecond) : 1;
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(TicksPerSecond - 1);

  typedef enum logic [2:0] {
    MODE_SAFE     = 3'd0,
    MODE_IDLE     = 3'd1,
    MODE_GRINDSET = 3'd2,
    MODE_GRIND    = 3'd3,
    MODE_PAUSESET = 3'd4,
    MODE_PAUSE    = 3'd5
  } mode_e;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase of an APB write;
  // addresses past the last register are ignored.
  // ---------------------------------------------------------------------------
  logic [7:0]  pause_seconds_q;
  logic [5:0]  grind_offset_q;
  logic [5:0]  press_gain_q;
  logic [5:0]  release_gain_q;
  logic [6:0]  debounce_limit_q;
  logic [7:0]  ramp_step_q;
  logic [11:0] ramp_peak_q;

  logic     cfg_wr;
  cfg_reg_e cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_seconds_q  <= PAUSE_SECONDS_RST;
      grind_offset_q   <= GRIND_OFFSET_RST;
      press_gain_q     <= PRESS_GAIN_RST;
      release_gain_q   <= RELEASE_GAIN_RST;
      debounce_limit_q <= DEBOUNCE_LIMIT_RST;
      ramp_step_q      <= RAMP_STEP_RST;
      ramp_peak_q      <= RAMP_PEAK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PAUSE_SECONDS:  pause_seconds_q  <= pwdata[7:0];
        REG_GRIND_OFFSET:   grind_offset_q   <= pwdata[5:0];
        REG_PRESS_GAIN:     press_gain_q     <= pwdata[5:0];
        REG_RELEASE_GAIN:   release_gain_q   <= pwdata[5:0];
        REG_DEBOUNCE_LIMIT: debounce_limit_q <= pwdata[6:0];
        REG_RAMP_STEP:      ramp_step_q      <= pwdata[7:0];
        REG_RAMP_PEAK:      ramp_peak_q      <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PAUSE_SECONDS:  prdata = {24'd0, pause_seconds_q};
      REG_GRIND_OFFSET:   prdata = {26'd0, grind_offset_q};
      REG_PRESS_GAIN:     prdata = {26'd0, press_gain_q};
      REG_RELEASE_GAIN:   prdata = {26'd0, release_gain_q};
      REG_DEBOUNCE_LIMIT: prdata = {25'd0, debounce_limit_q};
      REG_RAMP_STEP:      prdata = {24'd0, ramp_step_q};
      REG_RAMP_PEAK:      prdata = {20'd0, ramp_peak_q};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register and flow control. The controller steps ("advance") when a
  // tick is held and the result slot is free or being emptied this cycle.
  // ---------------------------------------------------------------------------
  logic        in_vld_q;
  logic        btn_q, joy_q, trip_q, adcv_q;
  logic [11:0] adc_q;
  logic        out_vld_q;
  logic        advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      btn_q  <= button_level_i;
      joy_q  <= joystick_centre_i;
      trip_q <= safety_trip_i;
      adc_q  <= adc_sample_i;
      adcv_q <= adc_valid_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state. These registers are also the result register: they
  // change only when a tick is processed, which is when out_valid_o is set.
  // ---------------------------------------------------------------------------
  mode_e              mode_q, mode_d;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [7:0]         grind_q, grind_d;
  logic [7:0]         pause_q, pause_d;
  logic signed [7:0]  hist_q, hist_d;
  logic signed [1:0]  prev_q, prev_d;
  logic               pressed_q, pressed_d;
  logic signed [13:0] ramp_q, ramp_d;
  logic               motor_q, motor_d;
  logic               green_q, green_d;
  logic               red_q, red_d;
  logic [11:0]        blue_q, blue_d;

  // Debouncer step, computed every cycle and committed only where the
  // controller samples the button. The history adds the weighted current
  // sample and removes the weighted previous one, then clamps at +/- limit.
  logic signed [9:0]  gain_term, rel_term, lim_pos, hist_sum, hist_clip;
  logic               db_pressed;
  logic signed [1:0]  db_sample;

  always_comb begin
    gain_term = $signed({4'd0, press_gain_q});
    if (!btn_q) begin
      gain_term = -gain_term;
    end
    rel_term = $signed({4'd0, release_gain_q});
    if (prev_q == 2'sd0) begin
      rel_term = 10'sd0;
    end else if (prev_q < 2'sd0) begin
      rel_term = -rel_term;
    end
    lim_pos   = $signed({3'd0, debounce_limit_q});
    hist_sum  = 10'(hist_q) + gain_term - rel_term;
    hist_clip = hist_sum;
    db_pressed = pressed_q;
    if (hist_clip >= lim_pos) begin
      hist_clip  = lim_pos;
      db_pressed = 1'b1;
    end
    if (hist_clip <= -lim_pos) begin
      hist_clip  = -lim_pos;
      db_pressed = 1'b0;
    end
    db_sample = btn_q ? 2'sd1 : -2'sd1;
  end

  // Breathing ramp: the ramp runs up by ramp_step and flips sign once it
  // reaches the peak, so its magnitude traces a triangle.
  logic signed [13:0] ramp_flip, ramp_next, ramp_mag;
  logic [11:0]        ramp_level;

  always_comb begin
    ramp_flip = ramp_q;
    if (ramp_q >= $signed({2'd0, ramp_peak_q})) begin
      ramp_flip = -ramp_q;
    end
    ramp_next  = ramp_flip + $signed({6'd0, ramp_step_q});
    ramp_mag   = (ramp_next < 14'sd0) ? -ramp_next : ramp_next;
    ramp_level = (ramp_mag > $signed({2'd0, BLUE_MAX})) ? BLUE_MAX : ramp_mag[11:0];
  end

  // Grind time from the potentiometer: reading / 25 + offset, capped at 255; zero without a valid conversion.
  logic [11:0] adc_masked;
  logic [24:0] div_prod;
  logic [8:0]  grind_sum;
  logic [7:0]  grind_load;

  always_comb begin
    adc_masked = adc_q & ADC_MASK;
    div_prod   = {13'd0, adc_masked} * {12'd0, DIV25_MUL};
    grind_sum  = {1'b0, div_prod[DIV25_SHIFT +: 8]} + {3'd0, grind_offset_q};
    grind_load = (grind_sum > 9'd255) ? 8'd255 : grind_sum[7:0];
    if (!adcv_q) begin
      grind_load = 8'd0;
    end
  end

  // One controller step per tick.
  logic       second;
  logic [7:0] grind_dec, pause_dec;
  logic       sample_en;

  always_comb begin
    phase_d   = (phase_q == PhaseLast) ? '0 : phase_q + 1'b1;
    second    = (phase_d == '0);
    grind_dec = (second && grind_q != 8'd0) ? grind_q - 8'd1 : grind_q;
    pause_dec = (second && pause_q != 8'd0) ? pause_q - 8'd1 : pause_q;

    mode_d    = mode_q;
    grind_d   = grind_q;
    pause_d   = pause_q;
    ramp_d    = ramp_q;
    motor_d   = motor_q;
    green_d   = green_q;
    red_d     = red_q;
    blue_d    = blue_q;
    sample_en = 1'b0;

    if (trip_q) begin
      mode_d  = MODE_SAFE;
      green_d = 1'b0;
      red_d   = 1'b1;
      blue_d  = 12'd0;
      motor_d = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_IDLE: begin
          pause_d   = 8'd0;
          motor_d   = 1'b0;
          ramp_d    = ramp_next;
          blue_d    = ramp_level;
          sample_en = 1'b1;
          if (db_pressed) begin
            blue_d  = 12'd0;
            grind_d = grind_load;
            mode_d  = MODE_GRINDSET;
          end
        end
        MODE_GRINDSET: begin
          sample_en = 1'b1;
          if (!db_pressed) begin
            mode_d  = MODE_GRIND;
            motor_d = 1'b1;
          end
        end
        MODE_GRIND: begin
          grind_d = grind_dec;
          if (grind_dec != 8'd0) begin
            sample_en = 1'b1;
            if (db_pressed) begin
              mode_d = MODE_PAUSESET;
            end
          end else begin
            motor_d = 1'b0;
            mode_d  = MODE_IDLE;
          end
        end
        MODE_PAUSESET: begin
          motor_d   = 1'b0;
          green_d   = 1'b1;
          sample_en = 1'b1;
          if (!db_pressed) begin
            pause_d = pause_seconds_q;
            mode_d  = MODE_PAUSE;
          end
        end
        MODE_PAUSE: begin
          pause_d   = pause_dec;
          sample_en = 1'b1;
          // An expiry and a press in the same tick end up in GrindSet.
          if (pause_dec == 8'd0) begin
            green_d = 1'b0;
            mode_d  = MODE_IDLE;
          end
          if (db_pressed) begin
            green_d = 1'b0;
            mode_d  = MODE_GRINDSET;
          end
        end
        default: begin
          // Safe, and any code outside the six states, waits for the
          // joystick centre press.
          mode_d = MODE_SAFE;
          if (joy_q) begin
            mode_d = MODE_IDLE;
            red_d  = 1'b0;
          end
        end
      endcase
    end

    if (sample_en) begin
      hist_d    = hist_clip[7:0];
      prev_d    = db_sample;
      pressed_d = db_pressed;
    end else begin
      hist_d    = hist_q;
      prev_d    = prev_q;
      pressed_d = pressed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_SAFE;
      phase_q   <= '0;
      grind_q   <= 8'd0;
      pause_q   <= 8'd0;
      hist_q    <= 8'sd0;
      prev_q    <= 2'sd0;
      pressed_q <= 1'b0;
      ramp_q    <= 14'sd1;
      motor_q   <= 1'b0;
      green_q   <= 1'b0;
      red_q     <= 1'b0;
      blue_q    <= 12'd0;
    end else if (advance) begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      grind_q   <= grind_d;
      pause_q   <= pause_d;
      hist_q    <= hist_d;
      prev_q    <= prev_d;
      pressed_q <= pressed_d;
      ramp_q    <= ramp_d;
      motor_q   <= motor_d;
      green_q   <= green_d;
      red_q     <= red_d;
      blue_q    <= blue_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign ctrl_state_o = mode_q;
  assign motor_on_o   = motor_q;
  assign green_led_o  = green_q;
  assign red_led_o    = red_q;
  assign blue_level_o = blue_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The motor only runs while grinding, and for the one tick in PauseSet that
  // follows a press during a grind, before PauseSet switches it off.
  a_motor_grind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    motor_q |-> ((mode_q == MODE_GRIND) || (mode_q == MODE_PAUSESET)))
    else $error("motor on outside the Grind and PauseSet states");

  // The red lamp is only lit in Safe.
  a_red_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_q |-> (mode_q == MODE_SAFE))
    else $error("red lamp lit outside the Safe state");

  // The breathing level is dark outside Idle.
  a_blue_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blue_q != 12'd0) |-> (mode_q == MODE_IDLE))
    else $error("blue lamp lit outside the Idle state");

  // A result that is not taken keeps the controller from stepping.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> ($stable(mode_q) && $stable(phase_q)))
    else $error("controller stepped while a result was waiting");

  // The tick phase stays inside one second.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhaseLast)
    else $error("tick phase out of range");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the debounced grinder controller: directed ticks,
// then randomized button sequences under several register settings, checked
// against an in-bench predictor. Depends on grind_pkg and the controller RTL.
module tb_top
  import grind_pkg::*;
();

  // Controller modes as they appear on ctrl_state_o.
  typedef enum logic [2:0] {
    MODE_SAFE     = 3'd0,
    MODE_IDLE     = 3'd1,
    MODE_GRINDSET = 3'd2,
    MODE_GRIND    = 3'd3,
    MODE_PAUSESET = 3'd4,
    MODE_PAUSE    = 3'd5
  } mode_e;

  // One 10 ms tick as offered on the input channel.
  typedef struct packed {
    logic        button;
    logic        joy;
    logic        trip;
    logic [11:0] adc;
    logic        valid;
  } tick_t;

  // Front panel after a tick: the fields of one result transaction.
  typedef struct packed {
    logic [2:0]  mode;
    logic        motor;
    logic        green;
    logic        red;
    logic [11:0] blue;
  } panel_t;

  // A directed tick; when typed is set, want is the known panel after it.
  typedef struct packed {
    tick_t  tick;
    logic   typed;
    panel_t want;
  } dir_row_t;

  localparam int NUM_REGS         = 7;
  localparam int ADC_STEP         = 25;   // ADC counts per second of grind
  localparam int NUM_PHASES       = 8;
  localparam int FIXED_PHASES     = 6;
  localparam int TICKS_PER_PHASE  = 150;
  localparam int LONG_HOLD_AT     = 500;  // result count at which the sink holds off
  localparam int LONG_HOLD_CYCLES = 90;
  localparam int TAIL_CYCLES      = 10;
  localparam int CYCLE_LIMIT      = 400000;

  localparam panel_t PANEL_NONE = '0;
  localparam panel_t PANEL_SAFE = '{MODE_SAFE, 1'b0, 1'b0, 1'b0, 12'd0};
  localparam panel_t PANEL_TRIP = '{MODE_SAFE, 1'b0, 1'b0, 1'b1, 12'd0};

  // Legal range of each register, indexed by cfg_reg_e.
  localparam logic [11:0] REG_LOW [NUM_REGS]  = '{1, 0, 1, 0, 1, 1, 16};
  localparam logic [11:0] REG_HIGH [NUM_REGS] = '{255, 63, 63, 63, 127, 255, 4095};

  // Register values for the directed part: single-tick debounce, no grind
  // offset, a small breathing peak and a zero-length pause, so that a pause
  // expires on its first tick and a press in that tick re-arms the grind.
  localparam logic [11:0] DIRECTED_REGS [NUM_REGS] = '{0, 0, 63, 0, 1, 255, 16};

  // Register values of the random phases; the last two phases draw their own.
  // Row one restores the reset values, rows two and three are the extremes,
  // and the last row runs with a zero debounce limit, which never presses.
  localparam logic [11:0] PHASE_REGS [FIXED_PHASES][NUM_REGS] = '{
    '{20, 5, 30, 10, 100, 8, 2048},
    '{255, 63, 63, 63, 127, 255, 4095},
    '{1, 0, 1, 0, 1, 1, 16},
    '{1, 0, 50, 20, 60, 200, 4000},
    '{2, 1, 20, 5, 30, 64, 1024},
    '{0, 63, 63, 63, 0, 1, 4095}
  };

  // Directed ticks. Rows with a typed panel: reset state, and safety trips.
  localparam dir_row_t DIR_ROWS [22] = '{
    '{'{0, 0, 0, 0, 0}, 1, PANEL_SAFE},     // after reset, joystick not centred
    '{'{1, 1, 1, 4095, 1}, 1, PANEL_TRIP},  // trip wins over everything else
    '{'{0, 1, 0, 0, 0}, 0, PANEL_NONE},     // joystick centre leaves safe
    '{'{0, 0, 0, 0, 0}, 0, PANEL_NONE},
    '{'{1, 0, 0, 0, 1}, 0, PANEL_NONE},     // press with ADC at zero
    '{'{0, 0, 0, 0, 0}, 0, PANEL_NONE},
    '{'{0, 0, 0, 0, 0}, 0, PANEL_NONE},     // zero grind ends at once
    '{'{1, 0, 0, 4095, 0}, 0, PANEL_NONE},  // conversion not valid
    '{'{0, 0, 0, 0, 0}, 0, PANEL_NONE},
    '{'{0, 0, 0, 0, 0}, 0, PANEL_NONE},
    '{'{1, 0, 0, 4095, 1}, 0, PANEL_NONE},  // full-scale grind time
    '{'{0, 0, 0, 0, 0}, 0, PANEL_NONE},
    '{'{1, 0, 0, 0, 0}, 0, PANEL_NONE},     // press during grind pauses
    '{'{0, 0, 0, 0, 0}, 0, PANEL_NONE},
    '{'{1, 0, 0, 0, 0}, 0, PANEL_NONE},     // pause expiry and press together
    '{'{0, 0, 0, 0, 0}, 0, PANEL_NONE},
    '{'{1, 0, 1, 4095, 1}, 1, PANEL_TRIP},  // trip with the motor running
    '{'{0, 0, 0, 0, 0}, 0, PANEL_NONE},
    '{'{0, 1, 0, 0, 0}, 0, PANEL_NONE},
    '{'{1, 0, 0, 24, 1}, 0, PANEL_NONE},    // just below one second
    '{'{0, 0, 0, 0, 0}, 0, PANEL_NONE},
    '{'{0, 0, 0, 0, 0}, 0, PANEL_NONE}
  };

  // ---------------------------------------------------------------------------
  // DUT signals. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic        button_level_i    = 1'b0;
  logic        joystick_centre_i = 1'b0;
  logic        safety_trip_i     = 1'b0;
  logic [11:0] adc_sample_i      = '0;
  logic        adc_valid_i       = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic [2:0]  ctrl_state_o;
  logic        motor_on_o;
  logic        green_led_o;
  logic        red_led_o;
  logic [11:0] blue_level_o;
  logic        psel              = 1'b0;
  logic        penable           = 1'b0;
  logic        pwrite            = 1'b0;
  logic [4:0]  paddr             = '0;
  logic [31:0] pwdata            = '0;
  logic [31:0] prdata;
  logic        pready;

  grinder_controller_debounced u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .button_level_i   (button_level_i),
    .joystick_centre_i(joystick_centre_i),
    .safety_trip_i    (safety_trip_i),
    .adc_sample_i     (adc_sample_i),
    .adc_valid_i      (adc_valid_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ctrl_state_o     (ctrl_state_o),
    .motor_on_o       (motor_on_o),
    .green_led_o      (green_led_o),
    .red_led_o        (red_led_o),
    .blue_level_o     (blue_level_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 2 ns clock.
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Bookkeeping.
  // ---------------------------------------------------------------------------
  panel_t      panel_due_q[$];     // panels still owed by the block, oldest first
  int          mismatches    = 0;
  int          ticks_sent    = 0;
  int          results_seen  = 0;
  int          settings_used = 0;
  int          mode_seen [6] = '{default: 0};
  int          cycle_count   = 0;
  logic        sender_eager  = 1'b0;  // no gaps between ticks while set
  logic        btn_level     = 1'b0;  // level of the current button run
  int          btn_run       = 0;     // ticks left in that run

  // Register copy used by the predictor, indexed by cfg_reg_e.
  logic [11:0] cfg_live [NUM_REGS] = '{PAUSE_SECONDS_RST, GRIND_OFFSET_RST,
                                       PRESS_GAIN_RST, RELEASE_GAIN_RST,
                                       DEBOUNCE_LIMIT_RST, RAMP_STEP_RST,
                                       RAMP_PEAK_RST};

  // Predicted controller state, starting from its reset values.
  mode_e       ctl_mode   = MODE_SAFE;
  int unsigned tick_phase = 0;
  int unsigned grind_secs = 0;
  int unsigned pause_secs = 0;
  int          btn_hist   = 0;
  int          btn_prev   = 0;
  logic        btn_down   = 1'b0;
  int          breath     = 1;
  logic        lit_motor  = 1'b0;
  logic        lit_green  = 1'b0;
  logic        lit_red    = 1'b0;
  logic [11:0] blue_width = '0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("tb_top: mismatch at result %0d: %s", results_seen, what);
  endtask

  // Integrating debouncer: the new sample adds press_gain, the previous one
  // takes away release_gain. The history clamps at +/- limit, and crossing
  // either clamp decides the debounced level; the released test comes last.
  function automatic logic debounce_button(input logic level);
    int s;
    int lim;
    s = level ? 1 : -1;
    lim = int'(cfg_live[REG_DEBOUNCE_LIMIT]);
    btn_hist += int'(cfg_live[REG_PRESS_GAIN]) * s - int'(cfg_live[REG_RELEASE_GAIN]) * btn_prev;
    if (btn_hist >= lim) begin
      btn_hist = lim;
      btn_down = 1'b1;
    end
    if (btn_hist <= -lim) begin
      btn_hist = -lim;
      btn_down = 1'b0;
    end
    btn_prev = s;
    return btn_down;
  endfunction

  // Steps the predicted controller by one tick and returns the panel after it.
  function automatic panel_t grind_tick(input tick_t t);
    logic second;
    int   mag;
    tick_phase = (tick_phase + 1 >= TICKS_PER_SECOND) ? 0 : tick_phase + 1;
    second = (tick_phase == 0);
    if (t.trip) begin
      // A trip overrides the controller for this tick; no button sample.
      ctl_mode   = MODE_SAFE;
      lit_green  = 1'b0;
      lit_red    = 1'b1;
      blue_width = '0;
      lit_motor  = 1'b0;
    end else begin
      case (ctl_mode)
        MODE_IDLE: begin
          pause_secs = 0;
          // Triangular breathing: the ramp flips sign at the peak, so it
          // climbs back through zero before rising again.
          lit_motor = 1'b0;
          if (breath >= int'(cfg_live[REG_RAMP_PEAK])) breath = -breath;
          breath += int'(cfg_live[REG_RAMP_STEP]);
          mag = (breath < 0) ? -breath : breath;
          blue_width = (mag > 4095) ? BLUE_MAX : 12'(mag);
          if (debounce_button(t.button)) begin
            blue_width = '0;
            if (!t.valid) begin
              grind_secs = 0;
            end else begin
              grind_secs = int'(t.adc & ADC_MASK) / ADC_STEP
                           + int'(cfg_live[REG_GRIND_OFFSET]);
              if (grind_secs > 255) grind_secs = 255;
            end
            ctl_mode = MODE_GRINDSET;
          end
        end
        MODE_GRINDSET: begin
          if (!debounce_button(t.button)) begin
            ctl_mode  = MODE_GRIND;
            lit_motor = 1'b1;
          end
        end
        MODE_GRIND: begin
          if (second && grind_secs > 0) grind_secs--;
          if (grind_secs > 0) begin
            if (debounce_button(t.button)) ctl_mode = MODE_PAUSESET;
          end else begin
            lit_motor = 1'b0;
            ctl_mode  = MODE_IDLE;
          end
        end
        MODE_PAUSESET: begin
          lit_motor = 1'b0;
          lit_green = 1'b1;
          if (!debounce_button(t.button)) begin
            pause_secs = 32'(cfg_live[REG_PAUSE_SECONDS]);
            ctl_mode   = MODE_PAUSE;
          end
        end
        MODE_PAUSE: begin
          if (second && pause_secs > 0) pause_secs--;
          if (pause_secs == 0) begin
            lit_green = 1'b0;
            ctl_mode  = MODE_IDLE;
          end
          // A press still counts in the tick the pause runs out.
          if (debounce_button(t.button)) begin
            lit_green = 1'b0;
            ctl_mode  = MODE_GRINDSET;
          end
        end
        default: begin
          ctl_mode = MODE_SAFE;
          if (t.joy) begin
            ctl_mode = MODE_IDLE;
            lit_red  = 1'b0;
          end
        end
      endcase
    end
    return '{ctl_mode, lit_motor, lit_green, lit_red, blue_width};
  endfunction

  // Random ticks: the button follows runs of one level, mostly short, some
  // long enough for a pause or a short grind to run out, with contact bounce
  // on top. Trips are rare; most ADC readings give grinds of a second or two.
  function automatic tick_t draw_tick();
    tick_t t;
    if (btn_run == 0) begin
      btn_level = ~btn_level;
      btn_run   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 10);
    end
    btn_run--;
    t.button = btn_level ^ ($urandom_range(0, 9) == 0);
    t.joy    = 1'($urandom_range(0, 1));
    t.trip   = ($urandom_range(0, 79) == 0);
    t.adc    = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                           : 12'($urandom_range(0, 74));
    t.valid  = ($urandom_range(0, 3) != 0);
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port. Writes take a setup and an access phase; the block is
  // idle whenever these run.
  // ---------------------------------------------------------------------------
  task automatic apb_write(input cfg_reg_e idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(input cfg_reg_e idx);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== 32'(cfg_live[idx]))
      flag_mismatch($sformatf("register %s reads %0h, holds %0h", idx.name(), prdata,
                              cfg_live[idx]));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes every register, then reads every one back.
  task automatic load_registers(input logic [11:0] regs [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_write(cfg_reg_e'(i), 32'(regs[i]));
      cfg_live[i] = regs[i];
    end
    for (int i = 0; i < NUM_REGS; i++) apb_read_check(cfg_reg_e'(i));
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Tick sender. Called at a falling edge; returns at a falling edge with the
  // accepted tick still on the wires, so the next call is the only driver of
  // in_valid_i at that edge.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input tick_t t, input logic typed, input panel_t want);
    int     gap;
    panel_t p;
    gap = sender_eager ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    button_level_i    <= t.button;
    joystick_centre_i <= t.joy;
    safety_trip_i     <= t.trip;
    adc_sample_i      <= t.adc;
    adc_valid_i       <= t.valid;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // Accepted at this edge: step the predictor now.
    p = grind_tick(t);
    panel_due_q.push_back(typed ? want : p);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Ends a burst of ticks and waits until every owed panel has arrived.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (panel_due_q.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink. Ready idles at random per transaction, with stretches of no
  // stalls, and once holds off long enough for the block to back up its input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int     hold;
    panel_t want;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (results_seen == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
      else if ((results_seen / 120) % 4 == 3) hold = 0;
      else hold = $urandom_range(0, 12);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (panel_due_q.size() == 0) begin
        flag_mismatch("result transaction with nothing expected");
      end else begin
        want = panel_due_q.pop_front();
        if (ctrl_state_o !== want.mode)
          flag_mismatch($sformatf("ctrl_state %0d, expected %0d", ctrl_state_o, want.mode));
        if (motor_on_o !== want.motor)
          flag_mismatch($sformatf("motor_on %b, expected %b", motor_on_o, want.motor));
        if (green_led_o !== want.green)
          flag_mismatch($sformatf("green_led %b, expected %b", green_led_o, want.green));
        if (red_led_o !== want.red)
          flag_mismatch($sformatf("red_led %b, expected %b", red_led_o, want.red));
        if (blue_level_o !== want.blue)
          flag_mismatch($sformatf("blue_level %0d, expected %0d", blue_level_o, want.blue));
      end
      if (ctrl_state_o < 6) mode_seen[ctrl_state_o]++;
      results_seen++;
    end
  end

  // Watchdog: far beyond the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: watchdog expired after %0d cycles", cycle_count);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, register check, directed ticks, then random phases,
  // each under its own register setting with the block drained in between.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [11:0] regs [NUM_REGS];
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers must read back their reset values before anything is written.
    for (int i = 0; i < NUM_REGS; i++) apb_read_check(cfg_reg_e'(i));

    load_registers(DIRECTED_REGS);
    foreach (DIR_ROWS[r]) send_tick(DIR_ROWS[r].tick, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < FIXED_PHASES) begin
        regs = PHASE_REGS[ph];
      end else begin
        for (int i = 0; i < NUM_REGS; i++)
          regs[i] = 12'($urandom_range(32'(REG_LOW[i]), 32'(REG_HIGH[i])));
      end
      load_registers(regs);
      // Every third phase offers ticks back to back.
      sender_eager = (ph % 3 == 1);
      for (int n = 0; n < TICKS_PER_PHASE; n++) send_tick(draw_tick(), 1'b0, PANEL_NONE);
      // The sender pauses here until the block has answered every tick.
      drain_results();
    end

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("tb_top: %0d ticks, %0d results checked, %0d register settings",
             ticks_sent, results_seen, settings_used);
    $display("tb_top: results per mode safe %0d idle %0d grindset %0d grind %0d pauseset %0d pause %0d",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4], mode_seen[5]);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
